// ===== design/tlsplit_pkg.sv =====
// ----------------------------------------------------------------------------
// Text line splitter package
// Shared types and constants for the mixed end-of-line text line splitter.
// ----------------------------------------------------------------------------
package tlsplit_pkg;

  localparam int unsigned UnitW = 16;
  localparam int unsigned MaxRes = 4;

  localparam logic [1:0] TYPE_UNIT = 2'd0;
  localparam logic [1:0] TYPE_EOL  = 2'd1;
  localparam logic [1:0] TYPE_EOS  = 2'd2;

  localparam logic [1:0] REG_CR_CODE   = 2'd0;
  localparam logic [1:0] REG_LF_CODE   = 2'd1;
  localparam logic [1:0] REG_BYTE_SWAP = 2'd2;

  typedef enum logic [2:0] {
    PH_EMPTY  = 3'd0,
    PH_DATA   = 3'd1,
    PH_CR     = 3'd2,
    PH_CRLF   = 3'd3,
    PH_LF     = 3'd4,
    PH_CRCR   = 3'd5,
    PH_CRCRLF = 3'd6
  } phase_e;

  typedef struct packed {
    logic [1:0]       item_type;
    logic [UnitW-1:0] code;
  } res_t;

  // Up to four results; slot 0 goes out first, cnt_m1 is the index of the last.
  typedef struct packed {
    logic [1:0]            cnt_m1;
    res_t [MaxRes-1:0]     res;
  } cmd_t;

endpackage

// ===== design/tlsplit_front.sv =====
// ----------------------------------------------------------------------------
// Text line splitter front end
// Accepts items, applies the byte swap, tracks the line phase and turns each
// item that causes results into a command holding them.
// ----------------------------------------------------------------------------
module tlsplit_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [tlsplit_pkg::UnitW-1:0] unit_i,
  input  logic [tlsplit_pkg::UnitW-1:0] cr_code_i,
  input  logic [tlsplit_pkg::UnitW-1:0] lf_code_i,
  input  logic                          byte_swap_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output tlsplit_pkg::cmd_t             cmd_o
);
  import tlsplit_pkg::*;

  phase_e           phase_q, phase_d, start_ph;
  logic [UnitW-1:0] cu;
  logic             is_cr, is_lf, accept, has_res;
  res_t             r_unit, r_cr, r_eol, r_eos;

  assign cu       = byte_swap_i ? {unit_i[7:0], unit_i[15:8]} : unit_i;
  assign is_lf    = (cu == lf_code_i);
  assign is_cr    = (cu == cr_code_i);
  assign start_ph = is_lf ? PH_LF : (is_cr ? PH_CR : PH_DATA);

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign r_unit = '{item_type: TYPE_UNIT, code: cu};
  assign r_cr   = '{item_type: TYPE_UNIT, code: cr_code_i};
  assign r_eol  = '{item_type: TYPE_EOL, code: '0};
  assign r_eos  = '{item_type: TYPE_EOS, code: '0};

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      if (kind_i) begin
        phase_d = PH_EMPTY;
      end else begin
        case (phase_q)
          PH_CR: begin
            if (is_lf) begin
              phase_d = PH_CRLF;
            end else if (is_cr) begin
              phase_d = PH_CRCR;
            end else begin
              phase_d = start_ph;
            end
          end
          PH_CRCR: begin
            phase_d = is_lf ? PH_CRCRLF : start_ph;
          end
          default: phase_d = start_ph;
        endcase
      end
    end
  end

  always_comb begin
    cmd_o   = '0;
    has_res = 1'b1;
    if (kind_i) begin
      case (phase_q)
        PH_EMPTY: begin
          cmd_o.cnt_m1 = 2'd0;
          cmd_o.res[0] = r_eos;
        end
        PH_CRCR: begin
          cmd_o.cnt_m1 = 2'd3;
          cmd_o.res[0] = r_eol;
          cmd_o.res[1] = r_cr;
          cmd_o.res[2] = r_eol;
          cmd_o.res[3] = r_eos;
        end
        default: begin
          cmd_o.cnt_m1 = 2'd1;
          cmd_o.res[0] = r_eol;
          cmd_o.res[1] = r_eos;
        end
      endcase
    end else begin
      case (phase_q)
        PH_CR: begin
          if (is_lf) begin
            cmd_o.cnt_m1 = 2'd0;
            cmd_o.res[0] = r_unit;
          end else if (is_cr) begin
            has_res = 1'b0;
          end else begin
            cmd_o.cnt_m1 = 2'd1;
            cmd_o.res[0] = r_eol;
            cmd_o.res[1] = r_unit;
          end
        end
        PH_CRCR: begin
          if (is_lf) begin
            cmd_o.cnt_m1 = 2'd1;
            cmd_o.res[0] = r_cr;
            cmd_o.res[1] = r_unit;
          end else begin
            cmd_o.cnt_m1 = 2'd3;
            cmd_o.res[0] = r_eol;
            cmd_o.res[1] = r_cr;
            cmd_o.res[2] = r_eol;
            cmd_o.res[3] = r_unit;
          end
        end
        PH_CRLF, PH_LF, PH_CRCRLF: begin
          cmd_o.cnt_m1 = 2'd1;
          cmd_o.res[0] = r_eol;
          cmd_o.res[1] = r_unit;
        end
        default: begin
          cmd_o.cnt_m1 = 2'd0;
          cmd_o.res[0] = r_unit;
        end
      endcase
    end
  end

  assign push_o = accept && has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_EMPTY;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

// ===== design/tlsplit_fifo.sv =====
// ----------------------------------------------------------------------------
// Text line splitter command queue
// Short queue of commands between the front end and the back end.
// ----------------------------------------------------------------------------
module tlsplit_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tlsplit_pkg::cmd_t wdata_i,
  input  logic              pop_i,
  output tlsplit_pkg::cmd_t rdata_o,
  output logic              empty_o,
  output logic              full_o
);
  import tlsplit_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FullCnt);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== design/tlsplit_back.sv =====
// ----------------------------------------------------------------------------
// Text line splitter back end
// Walks the results of the head command one per cycle into the output
// register while not held, and releases the command after its last result.
// ----------------------------------------------------------------------------
module tlsplit_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tlsplit_pkg::cmd_t             head_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    item_type_o,
  output logic [tlsplit_pkg::UnitW-1:0] out_unit_o,
  output logic                          last_o
);
  import tlsplit_pkg::*;

  logic       out_valid_q, out_valid_d, last_q, last_slot, load;
  logic [1:0] idx_q, idx_d;
  res_t       res_q, slot;

  assign load      = !out_valid_q || out_ready_i;
  assign slot      = head_i.res[idx_q];
  assign last_slot = (idx_q == head_i.cnt_m1);
  assign pop_o     = load && !empty_i && last_slot;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = !empty_i;
      if (!empty_i) begin
        idx_d = last_slot ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      res_q  <= slot;
      last_q <= last_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign item_type_o = res_q.item_type;
  assign out_unit_o  = res_q.code;
  assign last_o      = last_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> idx_q <= head_i.cnt_m1)
    else $error("Result index runs past the head command.");

  a_idx_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == 2'd0)
    else $error("Result index does not restart after a command is released.");

  a_eos_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_type_o == TYPE_EOS |-> last_o)
    else $error("End of stream is not the last result of its item.");

  a_type_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> item_type_o != 2'd3)
    else $error("Unknown result type on the output.");

endmodule

// ===== design/text_line_splitter_mixed_eol.sv =====
// ----------------------------------------------------------------------------
// Mixed end-of-line text line splitter
// Splits a stream of text code units into lines ended by LF, CR, CR LF or
// CR CR LF, passing every unit on with end-of-line and end-of-stream markers.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while its queue is not full and gives one
// result per cycle while out_ready_i is high. Most items cause exactly one
// result, so plain text flows at one item per clock. An item with more results
// holds the output until all are out; a held second CR causes none. A queue of
// QUEUE_DEPTH commands between the classifying front end and the output stage
// absorbs those bursts, and in_ready_o drops only while that queue is full.
// Results pass the queue and then the output register. Configuration registers
// sit at byte addresses 0 (cr_code), 4 (lf_code) and 8 (byte_swap).
module text_line_splitter_mixed_eol #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [tlsplit_pkg::UnitW-1:0] unit_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    item_type_o,
  output logic [tlsplit_pkg::UnitW-1:0] out_unit_o,
  output logic                          last_o
);
  import tlsplit_pkg::*;

  logic [UnitW-1:0] cr_code_q, lf_code_q;
  logic             byte_swap_q, wr_en, push, pop, q_empty, q_full;
  cmd_t             push_cmd, head_cmd;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_code_q   <= UnitW'(13);
      lf_code_q   <= UnitW'(10);
      byte_swap_q <= 1'b0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_CR_CODE:   cr_code_q   <= pwdata[UnitW-1:0];
        REG_LF_CODE:   lf_code_q   <= pwdata[UnitW-1:0];
        REG_BYTE_SWAP: byte_swap_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CR_CODE:   prdata = {16'd0, cr_code_q};
      REG_LF_CODE:   prdata = {16'd0, lf_code_q};
      REG_BYTE_SWAP: prdata = {31'd0, byte_swap_q};
      default:       prdata = '0;
    endcase
  end

  tlsplit_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .unit_i      (unit_i),
    .cr_code_i   (cr_code_q),
    .lf_code_i   (lf_code_q),
    .byte_swap_i (byte_swap_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  tlsplit_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  tlsplit_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .item_type_o (item_type_o),
    .out_unit_o  (out_unit_o),
    .last_o      (last_o)
  );

endmodule
